// ----- hw/rtl/mpwd_pkg.sv -----
// Shared types, codes and reset constants for the Manchester pulse-width decoder.
// Depends on nothing; the top, front and back files import it.
package mpwd_pkg;

    // Widths of the configuration registers, pulse durations, bus and result fields
    localparam int CFG_W     = 15;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int COUNT_W   = 8;
    localparam int DATA_W    = 32;

    // Register reset values
    localparam logic [CFG_W-1:0] HALF_BIT_RESET  = 15'd416;
    localparam logic [CFG_W-1:0] FULL_BIT_RESET  = 15'd833;
    localparam logic [CFG_W-1:0] TOLERANCE_RESET = 15'd105;

    // Default queue depths
    localparam int CMD_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_HALF_BIT  = 2'd0;
    localparam logic [1:0] REG_FULL_BIT  = 2'd1;
    localparam logic [1:0] REG_TOLERANCE = 2'd2;

    typedef enum logic [1:0] {
        PH_START    = 2'd0,
        PH_BOUNDARY = 2'd1,
        PH_SECOND   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_START  = 3'd1,
        ST_BAD_SECOND = 3'd2,
        ST_ENDED_LOW  = 3'd3,
        ST_INVALID    = 3'd4
    } status_t;

    typedef struct packed {
        logic [CFG_W-1:0] half_bit_us;
        logic [CFG_W-1:0] full_bit_us;
        logic [CFG_W-1:0] tolerance_us;
    } cfg_t;

    // Classified pulse passed from front to back
    typedef struct packed {
        logic level;
        logic last;
        logic padding;
        logic is_half;
        logic is_full;
    } cmd_t;

    // One frame result
    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   bit_count;
        logic [DATA_W-1:0]    data_bits;
    } res_t;

endpackage

// ----- hw/rtl/manchester_pulse_width_decoder.sv -----
// Manchester pulse-width decoder: one pulse per cycle sustained while neither side
// stalls. An accepted pulse is classified and written to a command queue at once;
// the decoder takes it from that queue's registers, and a frame result is written
// into the result queue's registers when the decoder takes the last pulse. Rate is
// set by the decoder update; both queues let either side stall without stopping the other.
// There is no clearing pass after reset. Configuration lives at byte addresses
// 0 (half_bit_us), 4 (full_bit_us) and 8 (tolerance_us), 15 bits each.
// Depends on mpwd_pkg, mpwd_fifo, mpwd_front and mpwd_back.
module manchester_pulse_width_decoder #(
    parameter int CMD_DEPTH = mpwd_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH = mpwd_pkg::RES_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mpwd_pkg::PADDR_W-1:0]    paddr,
    input  logic [mpwd_pkg::PDATA_W-1:0]    pwdata,
    output logic [mpwd_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            push,
    output logic                            full,
    input  logic                            pulse_level,
    input  logic [mpwd_pkg::CFG_W-1:0]      duration_us,
    input  logic                            last_pulse,
    output logic                            empty,
    input  logic                            pop,
    output logic [2:0]                      status,
    output logic [mpwd_pkg::COUNT_W-1:0]    bit_count,
    output logic [mpwd_pkg::DATA_W-1:0]     data_bits
);
    import mpwd_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    logic              cfg_we;
    logic [1:0]        reg_idx;
    cmd_t              cmd_in, cmd_out;
    logic [$bits(cmd_t)-1:0] cmd_rd;
    logic              cmd_empty, cmd_pop;
    res_t              res_in, res_out;
    logic [$bits(res_t)-1:0] res_rd;
    logic              res_full, res_push;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx)
                REG_HALF_BIT:  cfg_next.half_bit_us  = pwdata[CFG_W-1:0];
                REG_FULL_BIT:  cfg_next.full_bit_us  = pwdata[CFG_W-1:0];
                REG_TOLERANCE: cfg_next.tolerance_us = pwdata[CFG_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HALF_BIT:  prdata = PDATA_W'(cfg_reg.half_bit_us);
            REG_FULL_BIT:  prdata = PDATA_W'(cfg_reg.full_bit_us);
            REG_TOLERANCE: prdata = PDATA_W'(cfg_reg.tolerance_us);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_us  <= HALF_BIT_RESET;
            cfg_reg.full_bit_us  <= FULL_BIT_RESET;
            cfg_reg.tolerance_us <= TOLERANCE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify incoming pulses
    mpwd_front u_front (
        .cfg         (cfg_reg),
        .pulse_level (pulse_level),
        .duration_us (duration_us),
        .last_pulse  (last_pulse),
        .cmd         (cmd_in)
    );

    // Queue classified pulses
    mpwd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (cmd_empty)
    );

    assign cmd_out = cmd_t'(cmd_rd);

    // Decode frames
    mpwd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Queue frame results
    mpwd_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign res_out   = res_t'(res_rd);
    assign status    = res_out.status;
    assign bit_count = res_out.bit_count;
    assign data_bits = res_out.data_bits;

endmodule

// ----- hw/rtl/mpwd_fifo.sv -----
// Small register FIFO used for the command queue and the result queue.
// Depends on nothing; width and depth come from parameters (DEPTH >= 2).
module mpwd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hw/rtl/mpwd_front.sv -----
// Front end: classifies each pulse against the half-bit and full-bit windows.
// Depends on mpwd_pkg; feeds the command queue.
module mpwd_front (
    input  mpwd_pkg::cfg_t                  cfg,
    input  logic                            pulse_level,
    input  logic [mpwd_pkg::CFG_W-1:0]      duration_us,
    input  logic                            last_pulse,
    output mpwd_pkg::cmd_t                  cmd
);
    import mpwd_pkg::*;

    // Exclusive window test: nom - tol < d < nom + tol
    function automatic logic in_window(
        input logic [CFG_W-1:0] d,
        input logic [CFG_W-1:0] nom,
        input logic [CFG_W-1:0] tol
    );
        logic [CFG_W+1:0] lo;
        logic [CFG_W:0]   hi;
        logic             above, below;
        lo    = {2'b00, nom} - {2'b00, tol};
        hi    = {1'b0, nom} + {1'b0, tol};
        above = $signed({2'b00, d}) > $signed(lo);
        below = {1'b0, d} < hi;
        in_window = above & below;
    endfunction

    // Build the classified pulse
    always_comb
    begin
        cmd.level   = pulse_level;
        cmd.last    = last_pulse;
        cmd.padding = last_pulse & ~pulse_level & (duration_us == '0);
        cmd.is_half = in_window(duration_us, cfg.half_bit_us, cfg.tolerance_us);
        cmd.is_full = in_window(duration_us, cfg.full_bit_us, cfg.tolerance_us);
    end

endmodule

// ----- hw/rtl/mpwd_back.sv -----
// Back end: runs the frame decoder on classified pulses and emits frame results.
// Depends on mpwd_pkg; pops the command queue and pushes the result queue.
module mpwd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  mpwd_pkg::cmd_t  cmd,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    input  logic            res_full,
    output logic            res_push,
    output mpwd_pkg::res_t  res
);
    import mpwd_pkg::*;

    phase_t              phase_reg, phase_next, phase_upd;
    logic                cur_reg, cur_next, cur_upd;
    logic [DATA_W-1:0]   shift_reg, shift_next, shift_upd;
    logic [COUNT_W-1:0]  bits_reg, bits_next, bits_upd;
    logic                prior_reg, prior_next, prior_upd;
    status_t             err_reg, err_next, err_upd;
    logic                consume;

    // Take a pulse unless it ends a frame and the result queue is full
    assign consume  = ~cmd_empty & (~cmd.last | ~res_full);
    assign cmd_pop  = consume;
    assign res_push = consume & cmd.last;

    // Next state: apply the pulse, then clear the frame on its last pulse
    always_comb
    begin
        phase_upd = phase_reg;
        cur_upd   = cur_reg;
        shift_upd = shift_reg;
        bits_upd  = bits_reg;
        prior_upd = prior_reg;
        err_upd   = err_reg;
        if (err_reg == ST_OK)
        begin
            case (phase_reg)
                PH_BOUNDARY:
                begin
                    if (cmd.padding)
                    begin
                        err_upd = ST_OK;
                    end
                    else if (cmd.is_half)
                    begin
                        if (cmd.last)
                        begin
                            if (!cmd.level)
                            begin
                                err_upd = ST_ENDED_LOW;
                            end
                        end
                        else
                        begin
                            prior_upd = cmd.level;
                            phase_upd = PH_SECOND;
                        end
                    end
                    else if (cmd.is_full)
                    begin
                        cur_upd   = ~cur_reg;
                        shift_upd = {shift_reg[DATA_W-2:0], ~cur_reg};
                        bits_upd  = (bits_reg == '1) ? bits_reg : bits_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        err_upd = ST_INVALID;
                    end
                end
                PH_SECOND:
                begin
                    if (cmd.padding)
                    begin
                        if (!prior_reg)
                        begin
                            err_upd = ST_ENDED_LOW;
                        end
                    end
                    else if (cmd.is_half)
                    begin
                        shift_upd = {shift_reg[DATA_W-2:0], cur_reg};
                        bits_upd  = (bits_reg == '1) ? bits_reg : bits_reg + COUNT_W'(1);
                        phase_upd = PH_BOUNDARY;
                    end
                    else
                    begin
                        err_upd = ST_BAD_SECOND;
                    end
                end
                default:
                begin
                    if (!cmd.padding && cmd.level && cmd.is_half)
                    begin
                        phase_upd = PH_BOUNDARY;
                    end
                    else
                    begin
                        err_upd = ST_BAD_START;
                    end
                end
            endcase
        end

        phase_next = phase_reg;
        cur_next   = cur_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        prior_next = prior_reg;
        err_next   = err_reg;
        if (consume)
        begin
            if (cmd.last)
            begin
                phase_next = PH_START;
                cur_next   = 1'b1;
                shift_next = '0;
                bits_next  = '0;
                prior_next = 1'b0;
                err_next   = ST_OK;
            end
            else
            begin
                phase_next = phase_upd;
                cur_next   = cur_upd;
                shift_next = shift_upd;
                bits_next  = bits_upd;
                prior_next = prior_upd;
                err_next   = err_upd;
            end
        end
    end

    // Outputs: frame result, zero fields on error
    always_comb
    begin
        res.status    = err_upd;
        res.bit_count = (err_upd == ST_OK) ? bits_upd : '0;
        res.data_bits = (err_upd == ST_OK) ? shift_upd : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            cur_reg   <= 1'b1;
            shift_reg <= '0;
            bits_reg  <= '0;
            prior_reg <= 1'b0;
            err_reg   <= ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            cur_reg   <= cur_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            prior_reg <= prior_next;
            err_reg   <= err_next;
        end
    end

    // A stored error holds until the frame's last pulse is taken
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK && !(consume && cmd.last)) |=> err_reg == $past(err_reg))
        else $error("decoder error code changed mid-frame");

    // The bit count only grows within a frame
    a_bits_grow: assert property (@(posedge clk) disable iff (!rst_n)
        !(consume && cmd.last) |=> bits_reg >= $past(bits_reg))
        else $error("bit count dropped within a frame");

    // Each frame end clears the frame state
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (phase_reg == PH_START && err_reg == ST_OK && bits_reg == '0))
        else $error("frame state not cleared after result");

endmodule
